// File: hw/rtl/lpc_pkg.sv
// Shared types and constants of the lexical path cleaner.
`default_nettype none

package lpc_pkg;

    // Default store depth in bytes.
    localparam int PATH_LEN_DEF = 4096;

    // Fixed field widths at the ports.
    localparam int IDX_W = 12;
    localparam int LEN_W = 13;

    // Character codes.
    localparam logic [7:0] SLASH_CH = 8'h2F;
    localparam logic [7:0] DOT_CH   = 8'h2E;
    localparam logic [7:0] NUL_CH   = 8'h00;

    // Item function codes.
    localparam logic FUNC_APPEND = 1'b0;
    localparam logic FUNC_READ   = 1'b1;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_STEP = 5'b00010,
        S_CHAR = 5'b00100,
        S_BT   = 5'b01000,
        S_EOP  = 5'b10000
    } t_state;

    // Store port strobes.
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // Top to sequencer.
    typedef struct packed {
        logic start;      // input transaction taken this cycle
        logic slot_free;  // output register can be loaded this cycle
    } t_seq_cmd;

    // Sequencer to top.
    typedef struct packed {
        logic busy;
        logic emit;       // result fields valid, load output register
    } t_seq_stat;

endpackage

`default_nettype wire

// File: hw/rtl/lpc_store.sv
// Byte store of the cleaned path: one write port, one registered read port.
`default_nettype none

module lpc_store
    import lpc_pkg::*;
#(
    parameter int PATH_LEN = PATH_LEN_DEF
) (
    input  wire logic                        i_clk,
    input  wire t_mem_ctl                    i_ctl,
    input  wire logic [$clog2(PATH_LEN)-1:0] i_waddr,
    input  wire logic [7:0]                  i_wdata,
    input  wire logic [$clog2(PATH_LEN)-1:0] i_raddr,
    output logic [7:0]                       o_rdata
);

    logic [7:0] r_mem [0:PATH_LEN-1];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: hw/rtl/lpc_seq.sv
// Cleaning sequencer: path state, element decisions and the backtrack scan.
`default_nettype none

module lpc_seq
    import lpc_pkg::*;
#(
    parameter int PATH_LEN = PATH_LEN_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire t_seq_cmd                      i_cmd,
    input  wire logic                          i_func,
    input  wire logic [7:0]                    i_path_char,
    input  wire logic                          i_end_of_path,
    input  wire logic [IDX_W-1:0]              i_read_index,
    output t_seq_stat                          o_stat,
    output logic                               o_done_res,
    output logic [$clog2(PATH_LEN+1)-1:0]      o_final_len,
    output logic [7:0]                         o_read_byte,
    output logic                               o_overflow,
    output t_mem_ctl                           o_mem_ctl,
    output logic [$clog2(PATH_LEN)-1:0]        o_mem_waddr,
    output logic [7:0]                         o_mem_wdata,
    output logic [$clog2(PATH_LEN)-1:0]        o_mem_raddr,
    input  wire logic [7:0]                    i_mem_rdata
);

    localparam int AW = $clog2(PATH_LEN);
    localparam int PW = $clog2(PATH_LEN + 1);
    localparam int CW = (PW > IDX_W) ? PW : IDX_W;
    localparam logic [PW-1:0] LIMIT = PW'(PATH_LEN);
    localparam logic [PW-1:0] ONE   = PW'(1);

    t_state          r_state, n_state;
    logic [PW-1:0]   r_wp, n_wp;
    logic [PW-1:0]   r_floor, n_floor;
    logic [PW-1:0]   r_esp, n_esp;
    logic [PW-1:0]   r_scan, n_scan;
    logic [PW-1:0]   r_final, n_final;
    logic [1:0]      r_elen, n_elen;
    logic            r_dots, n_dots;
    logic            r_rooted, n_rooted;
    logic            r_started, n_started;
    logic            r_ovf, n_ovf;

    // Item being worked on
    logic            r_func;
    logic [7:0]      r_char;
    logic            r_eop;
    logic [IDX_W-1:0] r_idx;

    // Path state as seen by this item (first byte opens a new path)
    logic            first_root, is_sep;
    logic [PW-1:0]   e_wp, e_floor, e_esp;
    logic [1:0]      e_elen;
    logic            e_dots, e_rooted, e_ovf;

    // Tentative byte write at e_wp
    logic            c_fits, c_ovf, c_dots, need_slash;
    logic [PW-1:0]   c_wp, c_esp;
    logic [1:0]      c_elen;

    // Element close
    logic [PW-1:0]   f_wp, f_esp, q0;
    logic [1:0]      f_elen;
    logic            f_dots;
    logic [PW-1:0]   fo_wp, fo_floor;
    logic            fo_scan;

    logic            do_fin, emit_want, hold, we_raw, re_raw;
    logic            res_done;
    logic [7:0]      res_byte;
    logic [PW-1:0]   scan_prev;
    logic [CW-1:0]   idx_in_ext, idx_cmp, fin_cmp;

    assign is_sep     = (r_char == SLASH_CH) || (r_char == NUL_CH);
    assign first_root = !r_started && (r_char == SLASH_CH);

    assign e_wp     = r_started ? r_wp : (first_root ? ONE : '0);
    assign e_floor  = r_started ? r_floor : e_wp;
    assign e_esp    = r_started ? r_esp : e_wp;
    assign e_elen   = r_started ? r_elen : 2'd0;
    assign e_dots   = r_started ? r_dots : 1'b1;
    assign e_rooted = r_started ? r_rooted : first_root;
    assign e_ovf    = r_started ? r_ovf : 1'b0;

    assign c_fits     = e_wp < LIMIT;
    assign c_wp       = c_fits ? (e_wp + ONE) : e_wp;
    assign c_ovf      = e_ovf | ~c_fits;
    assign c_elen     = (e_elen == 2'd3) ? 2'd3 : (e_elen + 2'd1);
    assign c_dots     = e_dots & (r_char == DOT_CH);
    assign c_esp      = ((r_state == S_STEP) && (e_elen == 2'd0)) ? e_wp : e_esp;
    assign need_slash = (e_elen == 2'd0) && (e_wp != PW'(e_rooted));

    assign f_wp   = is_sep ? e_wp   : c_wp;
    assign f_esp  = is_sep ? e_esp  : c_esp;
    assign f_elen = is_sep ? e_elen : c_elen;
    assign f_dots = is_sep ? e_dots : c_dots;
    assign q0     = f_esp - ONE;

    // "." drops itself, ".." drops the element before it, is kept, or drops itself at the root
    always_comb begin
        fo_wp    = f_wp;
        fo_floor = e_floor;
        fo_scan  = 1'b0;
        if (f_dots && (f_elen == 2'd1)) begin
            fo_wp = f_esp;
        end else if (f_dots && (f_elen == 2'd2)) begin
            if (f_esp > e_floor) begin
                if (q0 <= e_floor) begin
                    fo_wp = q0;
                end else begin
                    fo_scan = 1'b1;
                end
            end else if (!e_rooted) begin
                fo_floor = f_wp;
            end else begin
                fo_wp = f_esp;
            end
        end
    end

    assign scan_prev  = r_scan - ONE;
    assign idx_in_ext = CW'(i_read_index);
    assign idx_cmp    = CW'(r_idx);
    assign fin_cmp    = CW'(r_final);

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_floor   = r_floor;
        n_esp     = r_esp;
        n_scan    = r_scan;
        n_final   = r_final;
        n_elen    = r_elen;
        n_dots    = r_dots;
        n_rooted  = r_rooted;
        n_started = r_started;
        n_ovf     = r_ovf;
        we_raw      = 1'b0;
        re_raw      = 1'b0;
        o_mem_waddr = e_wp[AW-1:0];
        o_mem_wdata = r_char;
        o_mem_raddr = scan_prev[AW-1:0];
        do_fin    = 1'b0;
        emit_want = 1'b0;
        res_done  = 1'b0;
        res_byte  = 8'h00;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_state = S_STEP;
                    if (i_func == FUNC_READ) begin
                        re_raw      = 1'b1;
                        o_mem_raddr = idx_in_ext[AW-1:0];
                    end
                end
            end
            S_STEP: begin
                if (r_func == FUNC_READ) begin
                    emit_want = 1'b1;
                    res_byte  = (idx_cmp < fin_cmp) ? i_mem_rdata : 8'h00;
                    n_state   = S_IDLE;
                end else begin
                    n_started = 1'b1;
                    n_rooted  = e_rooted;
                    n_ovf     = e_ovf;
                    n_wp      = e_wp;
                    n_floor   = e_floor;
                    n_esp     = e_esp;
                    n_elen    = e_elen;
                    n_dots    = e_dots;
                    if (is_sep) begin
                        // leading root slash goes to entry zero
                        if (first_root) begin
                            we_raw      = 1'b1;
                            o_mem_waddr = '0;
                            o_mem_wdata = SLASH_CH;
                        end
                        do_fin = 1'b1;
                    end else if (need_slash) begin
                        we_raw      = c_fits;
                        o_mem_wdata = SLASH_CH;
                        n_wp        = c_wp;
                        n_ovf       = c_ovf;
                        n_esp       = c_esp;
                        n_state     = S_CHAR;
                    end else begin
                        we_raw = c_fits;
                        n_ovf  = c_ovf;
                        n_esp  = c_esp;
                        if (r_eop) begin
                            do_fin = 1'b1;
                        end else begin
                            n_wp      = c_wp;
                            n_elen    = c_elen;
                            n_dots    = c_dots;
                            emit_want = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                end
            end
            S_CHAR: begin
                we_raw = c_fits;
                n_ovf  = c_ovf;
                n_esp  = c_esp;
                if (r_eop) begin
                    do_fin = 1'b1;
                end else begin
                    n_wp      = c_wp;
                    n_elen    = c_elen;
                    n_dots    = c_dots;
                    emit_want = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_BT: begin
                if ((i_mem_rdata == SLASH_CH) || (scan_prev <= r_floor)) begin
                    n_wp = (i_mem_rdata == SLASH_CH) ? r_scan : scan_prev;
                    if (r_eop) begin
                        n_state = S_EOP;
                    end else begin
                        emit_want = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    re_raw = 1'b1;
                    n_scan = scan_prev;
                end
            end
            S_EOP: begin
                if (r_wp == '0) begin
                    we_raw      = 1'b1;
                    o_mem_waddr = '0;
                    o_mem_wdata = DOT_CH;
                    n_final     = ONE;
                end else begin
                    n_final = r_wp;
                end
                emit_want = 1'b1;
                res_done  = 1'b1;
                n_wp      = '0;
                n_floor   = '0;
                n_esp     = '0;
                n_elen    = 2'd0;
                n_dots    = 1'b1;
                n_rooted  = 1'b0;
                n_started = 1'b0;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_fin) begin
            n_wp    = fo_wp;
            n_floor = fo_floor;
            n_elen  = 2'd0;
            n_dots  = 1'b1;
            if (fo_scan) begin
                re_raw      = 1'b1;
                o_mem_raddr = q0[AW-1:0];
                n_scan      = q0;
                n_state     = S_BT;
            end else if (r_eop) begin
                n_state = S_EOP;
            end else begin
                emit_want = 1'b1;
                n_state   = S_IDLE;
            end
        end
    end

    // A result that cannot be placed freezes the whole step
    assign hold = emit_want & ~i_cmd.slot_free;

    assign o_mem_ctl.we = we_raw & ~hold;
    assign o_mem_ctl.re = re_raw & ~hold;
    assign o_stat.busy  = (r_state != S_IDLE);
    assign o_stat.emit  = emit_want & ~hold;
    assign o_done_res   = res_done;
    assign o_final_len  = res_done ? n_final : '0;
    assign o_read_byte  = res_byte;
    assign o_overflow   = n_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_wp      <= '0;
            r_floor   <= '0;
            r_esp     <= '0;
            r_final   <= '0;
            r_elen    <= 2'd0;
            r_dots    <= 1'b1;
            r_rooted  <= 1'b0;
            r_started <= 1'b0;
            r_ovf     <= 1'b0;
        end else if (!hold) begin
            r_state   <= n_state;
            r_wp      <= n_wp;
            r_floor   <= n_floor;
            r_esp     <= n_esp;
            r_final   <= n_final;
            r_elen    <= n_elen;
            r_dots    <= n_dots;
            r_rooted  <= n_rooted;
            r_started <= n_started;
            r_ovf     <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!hold) begin
            r_scan <= n_scan;
        end
        if ((r_state == S_IDLE) && i_cmd.start) begin
            r_func <= i_func;
            r_char <= i_path_char;
            r_eop  <= i_end_of_path;
            r_idx  <= i_read_index;
        end
    end

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= LIMIT)
        else $error("write position beyond store");

    a_floor_le_wp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_floor <= r_wp)
        else $error("backtrack floor above write position");

    a_scan_above_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BT) |-> (r_scan > r_floor))
        else $error("backtrack scan reached the floor");

    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_ctl.we && o_mem_ctl.re) |-> (o_mem_waddr != o_mem_raddr))
        else $error("store read and write hit the same entry");

    a_emit_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.emit |=> (r_state == S_IDLE))
        else $error("result emitted but item not finished");

endmodule

`default_nettype wire

// File: hw/rtl/lexical_path_cleaner_core.sv
// Top level of the lexical path cleaner: handshakes, output register, store.
`default_nettype none

// Channel   Dir  Handshake          Payload
// -------   ---  ---------          -------
// item      in   i_valid / o_stall  i_func, i_path_char, i_end_of_path, i_read_index
// result    out  o_valid / i_stall  o_done_res, o_clean_length, o_read_byte, o_overflow
//
// One transaction at a time. A read or a plain character passes through S_STEP; a character
// that opens a new element after others also through S_CHAR, and the last character ends in S_EOP.
// A ".." that removes an element scans back through the store, one byte per cycle,
// bounded by the single read port of the store.
// Reset (synchronous, active low) clears the path state; the store is left as is.
// A new transaction is taken while the previous result still sits in the output
// register; the step that produces the next result waits until that register frees.

module lexical_path_cleaner_core
    import lpc_pkg::*;
#(
    parameter int PATH_LEN = PATH_LEN_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // item channel
    input  wire logic             i_valid,
    output logic                  o_stall,
    input  wire logic             i_func,
    input  wire logic [7:0]       i_path_char,
    input  wire logic             i_end_of_path,
    input  wire logic [IDX_W-1:0] i_read_index,
    // result channel
    output logic                  o_valid,
    input  wire logic             i_stall,
    output logic                  o_done_res,
    output logic [LEN_W-1:0]      o_clean_length,
    output logic [7:0]            o_read_byte,
    output logic                  o_overflow
);

    localparam int AW = $clog2(PATH_LEN);
    localparam int PW = $clog2(PATH_LEN + 1);
    localparam int LW = (PW > LEN_W) ? PW : LEN_W;

    t_seq_cmd       seq_cmd;
    t_seq_stat      seq_stat;
    t_mem_ctl       mem_ctl;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [7:0]     mem_wdata, mem_rdata;

    logic           seq_done;
    logic [PW-1:0]  seq_len;
    logic [LW-1:0]  seq_len_ext;
    logic [7:0]     seq_byte;
    logic           seq_ovf;

    // Output register
    logic             r_ovalid;
    logic             r_done;
    logic [LEN_W-1:0] r_len;
    logic [7:0]       r_byte;
    logic             r_ovf;

    // The sequencer only takes items while idle
    assign o_stall           = seq_stat.busy;
    assign seq_cmd.start     = i_valid & ~seq_stat.busy;
    assign seq_cmd.slot_free = ~r_ovalid | ~i_stall;

    lpc_seq #(
        .PATH_LEN (PATH_LEN)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (seq_cmd),
        .i_func        (i_func),
        .i_path_char   (i_path_char),
        .i_end_of_path (i_end_of_path),
        .i_read_index  (i_read_index),
        .o_stat        (seq_stat),
        .o_done_res    (seq_done),
        .o_final_len   (seq_len),
        .o_read_byte   (seq_byte),
        .o_overflow    (seq_ovf),
        .o_mem_ctl     (mem_ctl),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata)
    );

    lpc_store #(
        .PATH_LEN (PATH_LEN)
    ) u_store (
        .i_clk   (i_clk),
        .i_ctl   (mem_ctl),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Length field is a fixed 13 bits wide whatever the store depth
    assign seq_len_ext = LW'(seq_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (seq_stat.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.emit) begin
            r_done <= seq_done;
            r_len  <= seq_len_ext[LEN_W-1:0];
            r_byte <= seq_byte;
            r_ovf  <= seq_ovf;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_done_res     = r_done;
    assign o_clean_length = r_len;
    assign o_read_byte    = r_byte;
    assign o_overflow     = r_ovf;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the lexical path cleaner core.
`timescale 1ns / 1ps

module tb;
    import lpc_pkg::*;

    localparam int unsigned STORE_DEPTH  = PATH_LEN_DEF;
    localparam int unsigned RANDOM_ITEMS = 600;
    localparam int unsigned QUIET_ITEMS  = 100;

    typedef logic [7:0] byte_q_t [$];

    // One expected result transaction.
    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] len;
        logic [7:0]       rbyte;
        logic             ovf;
    } clean_result_t;

    // All inputs hold known values from time zero.
    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_valid       = 1'b0;
    logic             i_func        = FUNC_APPEND;
    logic [7:0]       i_path_char   = 8'h00;
    logic             i_end_of_path = 1'b0;
    logic [IDX_W-1:0] i_read_index  = '0;
    logic             i_stall       = 1'b0;

    logic             o_stall;
    logic             o_valid;
    logic             o_done_res;
    logic [LEN_W-1:0] o_clean_length;
    logic [7:0]       o_read_byte;
    logic             o_overflow;

    lexical_path_cleaner_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_path_char    (i_path_char),
        .i_end_of_path  (i_end_of_path),
        .i_read_index   (i_read_index),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_done_res     (o_done_res),
        .o_clean_length (o_clean_length),
        .o_read_byte    (o_read_byte),
        .o_overflow     (o_overflow)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #20_000_000;
        $display("FAIL lexical_path_cleaner_core");
        $finish;
    end

    // ------------------------------------------------------------------
    // Shadow of the cleaner: the cleaned-path store plus the element
    // tracking registers. Updated once per accepted input transaction.
    // ------------------------------------------------------------------
    logic [7:0]  shadow_store [STORE_DEPTH];
    int unsigned wr_pos;       // next free store slot
    int unsigned bt_floor;     // a ".." never backs up below this
    int unsigned elem_start;   // slot where the open element begins
    int unsigned elem_len;     // bytes in the open element, saturates at 3
    bit          elem_dots;    // open element holds only dots so far
    bit          rooted;
    bit          started;      // first byte of the path has been seen
    int unsigned final_len;    // length of the last finished path
    bit          ovf_flag;

    clean_result_t expected_q [$];
    clean_result_t want;
    int unsigned   mismatch_count = 0;
    int unsigned   sent_count     = 0;
    bit            send_gaps      = 1'b1;
    bit            stall_gaps     = 1'b1;

    function automatic void store_push(input logic [7:0] c);
        if (wr_pos < STORE_DEPTH) begin
            shadow_store[wr_pos] = c;
            wr_pos++;
        end else begin
            ovf_flag = 1'b1;   // store full: byte is lost
        end
    endfunction

    // Bytes of an element go into the store as they arrive; on the
    // separator we decide whether to keep them, drop them, or back up.
    function automatic void close_element();
        int unsigned scan;
        if (elem_len != 0) begin
            if (elem_dots && elem_len == 1) begin
                wr_pos = elem_start;                       // "." vanishes
            end else if (elem_dots && elem_len == 2) begin
                if (elem_start > bt_floor) begin
                    // ".." eats the previous element back to its slash
                    scan = elem_start;
                    do begin
                        scan--;
                    end while (scan > bt_floor && shadow_store[scan] != SLASH_CH);
                    wr_pos = scan;
                end else if (!rooted) begin
                    bt_floor = wr_pos;                     // leading ".." is kept
                end else begin
                    wr_pos = elem_start;                   // "/.." is "/"
                end
            end
            elem_len  = 0;
            elem_dots = 1'b1;
        end
    endfunction

    function automatic void clear_path();
        wr_pos     = 0;
        bt_floor   = 0;
        elem_start = 0;
        elem_len   = 0;
        elem_dots  = 1'b1;
        rooted     = 1'b0;
        started    = 1'b0;
    endfunction

    function automatic clean_result_t clean_step(input logic func, input logic [7:0] c,
                                                 input logic eop,
                                                 input logic [IDX_W-1:0] idx);
        clean_result_t r;
        r = '0;
        if (func == FUNC_READ) begin
            if (idx < final_len)
                r.rbyte = shadow_store[idx];
        end else begin
            if (!started) begin
                // first byte of a path: clears the old overflow
                started  = 1'b1;
                ovf_flag = 1'b0;
                rooted   = (c == SLASH_CH);
                wr_pos   = 0;
                if (rooted)
                    store_push(SLASH_CH);
                bt_floor   = wr_pos;
                elem_start = wr_pos;
                elem_len   = 0;
                elem_dots  = 1'b1;
            end
            if (c == SLASH_CH || c == NUL_CH) begin
                close_element();
            end else begin
                if (elem_len == 0) begin
                    elem_start = wr_pos;
                    if (wr_pos != rooted)
                        store_push(SLASH_CH);
                end
                store_push(c);
                if (c != DOT_CH)
                    elem_dots = 1'b0;
                if (elem_len < 3)
                    elem_len++;
            end
            if (eop) begin
                close_element();
                if (wr_pos == 0)
                    store_push(DOT_CH);   // empty path cleans to "."
                final_len = wr_pos;
                r.done    = 1'b1;
                r.len     = LEN_W'(final_len);
                clear_path();
            end
        end
        r.ovf = ovf_flag;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts and the in-order scoreboard.
    // ------------------------------------------------------------------
    initial begin : stall_gen
        int unsigned burst;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (burst != 0) begin
                burst--;
                i_stall <= 1'b1;
            end else if (stall_gaps && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(0, 4);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string what, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (expected_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got done %0b len %0d byte %0d ovf %0b",
                         $time, o_done_res, o_clean_length, o_read_byte, o_overflow);
                mismatch_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("done_res", 16'(want.done), 16'(o_done_res));
                check_field("clean_length", 16'(want.len), 16'(o_clean_length));
                check_field("read_byte", 16'(want.rbyte), 16'(o_read_byte));
                check_field("overflow", 16'(want.ovf), 16'(o_overflow));
            end
        end
    end

    // ------------------------------------------------------------------
    // Item side. Every task starts and ends at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_item(input logic func, input logic [7:0] ch, input logic eop,
                             input logic [IDX_W-1:0] idx);
        if (send_gaps && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_path_char   <= ch;
        i_end_of_path <= eop;
        i_read_index  <= idx;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        expected_q.push_back(clean_step(func, ch, eop, idx));
        sent_count++;
        @(negedge i_clk);
    endtask

    // Unused payload fields carry random bits.
    task automatic send_read(input logic [IDX_W-1:0] idx);
        send_item(FUNC_READ, 8'($urandom), 1'($urandom), idx);
    endtask

    // Mostly indices from zero up to the length of the last finished path, sometimes anywhere.
    function automatic logic [IDX_W-1:0] pick_index();
        if (final_len != 0 && $urandom_range(0, 3) != 0)
            return IDX_W'($urandom_range(0, (final_len > 4095) ? 4095 : final_len));
        return IDX_W'($urandom);
    endfunction

    // Sends one path, with read transactions mixed in at read_pct percent.
    task automatic send_seq(input byte_q_t seq, input int unsigned read_pct);
        for (int i = 0; i < seq.size(); i++) begin
            if ($urandom_range(0, 99) < read_pct)
                send_read(pick_index());
            send_item(FUNC_APPEND, seq[i], i == seq.size() - 1, IDX_W'($urandom));
        end
    endtask

    task automatic send_path(input string s);
        byte_q_t seq;
        for (int i = 0; i < s.len(); i++)
            seq.push_back(s[i]);
        send_seq(seq, 0);
    endtask

    // Sender holds off until the scoreboard is empty.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] name_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == SLASH_CH || c == DOT_CH);
        return c;
    endfunction

    // Path longer than the store: plain names, an odd doubled slash, optionally a trailing "/..".
    function automatic byte_q_t long_path(input bit rooted_p, input bit tail_dotdot);
        byte_q_t seq;
        if (rooted_p)
            seq.push_back(SLASH_CH);
        while (seq.size() < STORE_DEPTH + 128) begin
            repeat ($urandom_range(1, 12)) seq.push_back(name_char());
            seq.push_back(SLASH_CH);
            if ($urandom_range(0, 15) == 0)
                seq.push_back(SLASH_CH);
        end
        repeat (3) seq.push_back(name_char());
        if (tail_dotdot) begin
            seq.push_back(SLASH_CH);
            seq.push_back(DOT_CH);
            seq.push_back(DOT_CH);
        end
        return seq;
    endfunction

    // Well-formed paths with random elements, plus some raw noise.
    function automatic byte_q_t random_path();
        byte_q_t     seq;
        int unsigned kind;
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 10)) seq.push_back(8'($urandom_range(0, 255)));
            return seq;
        end
        if ($urandom_range(0, 1) == 1)
            seq.push_back(SLASH_CH);
        repeat ($urandom_range(0, 6)) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2, 3: begin
                    repeat ($urandom_range(1, 8))
                        seq.push_back(($urandom_range(0, 3) == 0) ? DOT_CH : name_char());
                end
                4:       seq.push_back(DOT_CH);
                5, 6, 7: repeat (2) seq.push_back(DOT_CH);
                8:       repeat (3) seq.push_back(DOT_CH);
                default: repeat (4) seq.push_back(DOT_CH);
            endcase
            seq.push_back(($urandom_range(0, 15) == 0) ? NUL_CH : SLASH_CH);
            if ($urandom_range(0, 7) == 0)
                seq.push_back(SLASH_CH);
        end
        if (seq.size() == 0)
            seq.push_back(($urandom_range(0, 1) == 1) ? DOT_CH : SLASH_CH);
        else if (seq.size() > 1 && $urandom_range(0, 3) != 0 &&
                 (seq[$] == SLASH_CH || seq[$] == NUL_CH))
            void'(seq.pop_back());
        return seq;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Nothing finished yet: every read returns zero.
    task automatic test_after_reset();
        send_read('0);
        send_read('1);
        send_read(IDX_W'($urandom));
    endtask

    task automatic test_directed_paths();
        byte_q_t seq;
        send_path("/..");             // rooted ".." at the top collapses to "/"
        send_path("../../a/..");      // leading ".." elements are kept
        send_path("a//./b/../...");   // repeated slash, dot, backtrack, triple dot
        send_path("./");              // empty result becomes "."
        // NUL acts as a separator; extreme byte values in names
        seq.push_back(8'h01);
        seq.push_back(NUL_CH);
        seq.push_back(8'hFF);
        seq.push_back(SLASH_CH);
        seq.push_back(DOT_CH);
        send_seq(seq, 0);
        for (int i = 0; i < 4; i++)
            send_read(IDX_W'(i));
    endtask

    // Paths longer than the store: truncation, overflow flag, ".." on the
    // truncated store, and the flag clearing on the next path.
    task automatic test_store_overflow();
        send_seq(long_path(1'b0, 1'b0), 2);
        send_read('1);
        send_read('0);
        send_read(pick_index());
        send_seq(long_path(1'b1, 1'b1), 2);
        send_read('1);
        send_read(IDX_W'(final_len - 1));
        send_read(pick_index());
        send_path("x");
        send_read('0);
    endtask

    task automatic test_random_paths();
        int unsigned first;
        bit          paused;
        first  = sent_count;
        paused = 1'b0;
        while (sent_count - first < RANDOM_ITEMS) begin
            if (sent_count - first >= RANDOM_ITEMS - QUIET_ITEMS) begin
                send_gaps  = 1'b0;
                stall_gaps = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
                send_gaps  = ($urandom_range(0, 2) != 0);
                stall_gaps = ($urandom_range(0, 2) != 0);
            end
            if (!paused && sent_count - first >= RANDOM_ITEMS / 2) begin
                drain();
                paused = 1'b1;
            end
            send_seq(random_path(), 15);
        end
    endtask

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++)
            shadow_store[i] = 8'h00;
        clear_path();
        final_len = 0;
        ovf_flag  = 1'b0;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_after_reset();
        test_directed_paths();
        test_store_overflow();
        test_random_paths();

        drain();
        stall_gaps = 1'b0;
        repeat (32) @(posedge i_clk);
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("PASS lexical_path_cleaner_core");
        else
            $display("FAIL lexical_path_cleaner_core");
        $finish;
    end

endmodule
